[src/assert_macros.svh]
// Assertion helpers for the button press qualifier.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
      else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
      else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst, lhs, rhs)
`define ASSERT_NEXT(label, clk, rst, lhs, rhs)
`endif
`endif

[src/bpq_pkg.sv]
package bpq_pkg;

   localparam int COUNT_BITS = 16;
   localparam int CFG_BITS = 16;
   localparam int CMP_BITS = (COUNT_BITS > CFG_BITS) ? COUNT_BITS : CFG_BITS;
   localparam int CSR_INDEX_BITS = 2;

   localparam logic [CFG_BITS-1:0] DEBOUNCE_RESET = CFG_BITS'(40);
   localparam logic [CFG_BITS-1:0] LONG_PRESS_RESET = CFG_BITS'(5000);

   localparam logic [CSR_INDEX_BITS-1:0] CSR_DEBOUNCE = CSR_INDEX_BITS'(0);
   localparam logic [CSR_INDEX_BITS-1:0] CSR_LONG_PRESS = CSR_INDEX_BITS'(1);

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

   typedef enum logic [1:0] {
      PHASE_IDLE        = 2'd0,
      PHASE_DEB_PRESS   = 2'd1,
      PHASE_HELD        = 2'd2,
      PHASE_DEB_RELEASE = 2'd3
   } phase_type;

   typedef struct packed {
      phase_type              phase;
      logic [COUNT_BITS-1:0]  ticks_since_change;
      logic [COUNT_BITS-1:0]  ticks_held;
      logic                   long_reported;
   } state_type;

   typedef struct packed {
      logic       short_press;
      logic       long_press;
      phase_type  phase;
   } result_type;

endpackage

[src/bpq_step.sv]
module bpq_step (
   input  bpq_pkg::state_type                 state_cur,
   input  logic                               btn_down,
   input  logic                               edge_seen,
   input  logic [bpq_pkg::CFG_BITS-1:0]       debounce_ticks,
   input  logic [bpq_pkg::CFG_BITS-1:0]       long_press_ticks,
   output bpq_pkg::state_type                 state_nxt,
   output bpq_pkg::result_type                result
);

   logic [bpq_pkg::COUNT_BITS-1:0] tsc;
   logic [bpq_pkg::COUNT_BITS-1:0] held;
   logic                           deb_done;
   logic                           long_due;
   bpq_pkg::phase_type             ph;

   always_comb begin
      tsc = (state_cur.ticks_since_change == bpq_pkg::COUNT_MAX) ?
            state_cur.ticks_since_change :
            state_cur.ticks_since_change + bpq_pkg::COUNT_BITS'(1);
      held = (state_cur.ticks_held == bpq_pkg::COUNT_MAX) ?
             state_cur.ticks_held :
             state_cur.ticks_held + bpq_pkg::COUNT_BITS'(1);
      ph = state_cur.phase;
      if (edge_seen && (ph == bpq_pkg::PHASE_IDLE)) begin
         ph = bpq_pkg::PHASE_DEB_PRESS;
         tsc = '0;
      end
      deb_done = bpq_pkg::CMP_BITS'(tsc) >= bpq_pkg::CMP_BITS'(debounce_ticks);
      long_due = bpq_pkg::CMP_BITS'(held) >= bpq_pkg::CMP_BITS'(long_press_ticks);

      state_nxt.phase = ph;
      state_nxt.ticks_since_change = tsc;
      state_nxt.ticks_held = held;
      state_nxt.long_reported = state_cur.long_reported;
      result.short_press = 1'b0;
      result.long_press = 1'b0;

      case (ph)
         bpq_pkg::PHASE_DEB_PRESS: begin
            if (deb_done) begin
               if (btn_down) begin
                  state_nxt.phase = bpq_pkg::PHASE_HELD;
                  state_nxt.ticks_held = '0;
                  state_nxt.long_reported = 1'b0;
                  if (bpq_pkg::CMP_BITS'(long_press_ticks) == '0) begin
                     // zero hold time: pulse is issued later in the held check
                  end
               end else begin
                  state_nxt.phase = bpq_pkg::PHASE_IDLE;
               end
            end
         end
         bpq_pkg::PHASE_HELD: begin
            if (!btn_down) begin
               state_nxt.phase = bpq_pkg::PHASE_DEB_RELEASE;
               state_nxt.ticks_since_change = '0;
            end else if (!state_cur.long_reported && long_due) begin
               state_nxt.long_reported = 1'b1;
               result.long_press = 1'b1;
            end
         end
         bpq_pkg::PHASE_DEB_RELEASE: begin
            if (deb_done) begin
               if (!btn_down) begin
                  result.short_press = !state_cur.long_reported;
                  state_nxt.phase = bpq_pkg::PHASE_IDLE;
               end else begin
                  state_nxt.phase = bpq_pkg::PHASE_HELD;
               end
            end
         end
         default: begin
         end
      endcase

      result.phase = state_nxt.phase;
   end

endmodule

[src/bpq_out.sv]
module bpq_out (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  bpq_pkg::result_type  in_result,
   output logic                 in_stall,
   output logic                 out_valid,
   output bpq_pkg::result_type  out_result,
   input  logic                 out_stall
);

   logic                 out_valid_ff;
   logic                 out_valid_in;
   bpq_pkg::result_type  out_result_ff;
   bpq_pkg::result_type  out_result_in;
   logic                 skid_valid_ff;
   logic                 skid_valid_in;
   bpq_pkg::result_type  skid_result_ff;
   bpq_pkg::result_type  skid_result_in;
   logic                 take;
   logic                 load;

   always_comb begin
      take = !skid_valid_ff && in_valid;
      load = !out_valid_ff || !out_stall;
      out_valid_in = out_valid_ff;
      out_result_in = out_result_ff;
      skid_valid_in = skid_valid_ff;
      skid_result_in = skid_result_ff;
      if (load) begin
         if (skid_valid_ff) begin
            out_valid_in = 1'b1;
            out_result_in = skid_result_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = take;
            out_result_in = in_result;
         end
      end else if (take) begin
         skid_valid_in = 1'b1;
         skid_result_in = in_result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_result_ff <= out_result_in;
      skid_result_ff <= skid_result_in;
   end

   assign in_stall = skid_valid_ff;
   assign out_valid = out_valid_ff;
   assign out_result = out_result_ff;

endmodule

[src/button_press_qualifier_core.sv]
// Button press qualifier: turns one sampled push button into short and long
// press pulses. Each req transaction is one millisecond tick carrying the
// pressed level and a latched press edge; each tick yields exactly one rsp
// transaction with the short pulse, long pulse and the phase after the tick.
// The csr channel writes the debounce time (index 0) and the long-press time
// (index 1); other indexes are ignored. csr_ready is always high, and the user
// must write the registers only while no tick is in flight; the block itself
// does not enforce this. A tick's result is registered before it shows on rsp.
// Throughput: one tick per cycle unless req_stall is high; the phase and counter
// update is a single pass of logic between the state and result registers.
// Stall: a two-entry output stage (result register plus skid register) keeps
// taking ticks while one result waits; req_stall rises only when both are
// full, and it comes from a register.
// Reset: phase idle, both counters and the long-press flag cleared, the
// registers at 40 and 5000 ticks, no result pending.
`include "assert_macros.svh"

module button_press_qualifier_core (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic                                  req_btn_down,
   input  logic                                  req_edge_seen,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic                                  rsp_short_press,
   output logic                                  rsp_long_press,
   output logic [1:0]                            rsp_phase,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [bpq_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [bpq_pkg::CFG_BITS-1:0]          csr_wdata
);

   logic [bpq_pkg::CFG_BITS-1:0]  debounce_ff;
   logic [bpq_pkg::CFG_BITS-1:0]  long_press_ff;
   bpq_pkg::state_type            state_ff;
   bpq_pkg::state_type            state_in;
   bpq_pkg::result_type           step_result;
   bpq_pkg::result_type           rsp_result;
   logic                          req_take;

   assign csr_ready = 1'b1;
   assign req_take = req_valid && !req_stall;

   bpq_step u_step (
      .state_cur        (state_ff),
      .btn_down         (req_btn_down),
      .edge_seen        (req_edge_seen),
      .debounce_ticks   (debounce_ff),
      .long_press_ticks (long_press_ff),
      .state_nxt        (state_in),
      .result           (step_result)
   );

   bpq_out u_out (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_valid),
      .in_result  (step_result),
      .in_stall   (req_stall),
      .out_valid  (rsp_valid),
      .out_result (rsp_result),
      .out_stall  (rsp_stall)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff <= bpq_pkg::DEBOUNCE_RESET;
         long_press_ff <= bpq_pkg::LONG_PRESS_RESET;
         state_ff.phase <= bpq_pkg::PHASE_IDLE;
         state_ff.ticks_since_change <= '0;
         state_ff.ticks_held <= '0;
         state_ff.long_reported <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               bpq_pkg::CSR_DEBOUNCE: begin
                  debounce_ff <= csr_wdata;
               end
               bpq_pkg::CSR_LONG_PRESS: begin
                  long_press_ff <= csr_wdata;
               end
               default: begin
               end
            endcase
         end
         if (req_take) begin
            state_ff <= state_in;
         end
      end
   end

   assign rsp_short_press = rsp_result.short_press;
   assign rsp_long_press = rsp_result.long_press;
   assign rsp_phase = rsp_result.phase;

   `ASSERT_IMPLIES(a_skid_needs_out, clock, reset, req_stall, rsp_valid)
   `ASSERT_IMPLIES(a_pulse_exclusive, clock, reset, rsp_valid,
      !(rsp_short_press && rsp_long_press))
   `ASSERT_IMPLIES(a_long_when_held, clock, reset, rsp_valid && rsp_long_press,
      rsp_phase == bpq_pkg::PHASE_HELD)
   `ASSERT_IMPLIES(a_short_when_idle, clock, reset, rsp_valid && rsp_short_press,
      rsp_phase == bpq_pkg::PHASE_IDLE)
   `ASSERT_NEXT(a_stall_from_full, clock, reset, !rsp_valid, !req_stall)

endmodule

[sim/tb_button_press_qualifier_core.sv]
`timescale 1ns / 100ps

module tb_button_press_qualifier_core;
   import bpq_pkg::*;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPARE_LO = CSR_INDEX_BITS'(2);
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPARE_HI = CSR_INDEX_BITS'(3);
   localparam int DRAIN_CYCLES = 4;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic                      req_btn_down = 1'b0;
   logic                      req_edge_seen = 1'b0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic                      rsp_short_press;
   logic                      rsp_long_press;
   logic [1:0]                rsp_phase;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index = CSR_DEBOUNCE;
   logic [CFG_BITS-1:0]       csr_wdata = '0;

   // press qualifier prediction state
   phase_type                 press_phase_q = PHASE_IDLE;
   logic [COUNT_BITS-1:0]     since_change_q = '0;
   logic [COUNT_BITS-1:0]     held_q = '0;
   logic                      long_done_q = 1'b0;
   logic [CFG_BITS-1:0]       debounce_q = DEBOUNCE_RESET;
   logic [CFG_BITS-1:0]       long_press_q = LONG_PRESS_RESET;
   result_type                expected_ticks[$];

   int  error_count = 0;
   int  ticks_checked = 0;
   int  short_pulses = 0;
   int  long_pulses = 0;
   int  csr_writes = 0;
   int  input_stall_cycles = 0;
   bit  gaps_on = 1'b1;
   int  burst_left = 0;
   int  hold_off_cycles = 0;
   int  stall_run = 0;
   int  free_run = 0;

   button_press_qualifier_core uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_btn_down    (req_btn_down),
      .req_edge_seen   (req_edge_seen),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_short_press (rsp_short_press),
      .rsp_long_press  (rsp_long_press),
      .rsp_phase       (rsp_phase),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic result_type qualify_tick(input logic pressed, input logic edge_flag);
      result_type r;
      r.short_press = 1'b0;
      r.long_press = 1'b0;
      if (since_change_q != COUNT_MAX) since_change_q = since_change_q + 1'b1;
      if (held_q != COUNT_MAX) held_q = held_q + 1'b1;
      if (edge_flag && press_phase_q == PHASE_IDLE) begin
         press_phase_q = PHASE_DEB_PRESS;
         since_change_q = '0;
      end
      case (press_phase_q)
         PHASE_DEB_PRESS: begin
            if (CMP_BITS'(since_change_q) >= CMP_BITS'(debounce_q)) begin
               if (pressed) begin
                  press_phase_q = PHASE_HELD;
                  held_q = '0;
                  long_done_q = 1'b0;
               end else begin
                  press_phase_q = PHASE_IDLE;
               end
            end
         end
         PHASE_HELD: begin
            if (!pressed) begin
               press_phase_q = PHASE_DEB_RELEASE;
               since_change_q = '0;
            end else if (!long_done_q && CMP_BITS'(held_q) >= CMP_BITS'(long_press_q)) begin
               long_done_q = 1'b1;
               r.long_press = 1'b1;
            end
         end
         PHASE_DEB_RELEASE: begin
            if (CMP_BITS'(since_change_q) >= CMP_BITS'(debounce_q)) begin
               if (!pressed) begin
                  if (!long_done_q) r.short_press = 1'b1;
                  press_phase_q = PHASE_IDLE;
               end else begin
                  press_phase_q = PHASE_HELD;
               end
            end
         end
         default: ;
      endcase
      r.phase = press_phase_q;
      return r;
   endfunction

   task automatic report_field(input string field, input int want, input int got);
      error_count++;
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, field, want, got);
   endtask

   always @(posedge clock) begin : monitor
      result_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            ticks_checked++;
            if (expected_ticks.size() == 0) begin
               error_count++;
               $display("%0t: result transaction with nothing expected, expected none actual %0b%0b%0d",
                        $time, rsp_short_press, rsp_long_press, rsp_phase);
            end else begin
               want = expected_ticks.pop_front();
               if (want.short_press) short_pulses++;
               if (want.long_press) long_pulses++;
               if (rsp_short_press !== want.short_press)
                  report_field("short_press", want.short_press, rsp_short_press);
               if (rsp_long_press !== want.long_press)
                  report_field("long_press", want.long_press, rsp_long_press);
               if (rsp_phase !== want.phase)
                  report_field("phase", want.phase, rsp_phase);
            end
         end
         if (req_valid && req_stall) input_stall_cycles++;
         if (req_valid && !req_stall)
            expected_ticks.push_back(qualify_tick(req_btn_down, req_edge_seen));
         if (csr_valid && csr_ready) begin
            csr_writes++;
            case (csr_index)
               CSR_DEBOUNCE:   debounce_q = csr_wdata;
               CSR_LONG_PRESS: long_press_q = csr_wdata;
               default: ;
            endcase
         end
      end
   end

   // result side stall pattern, plus the long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_off_cycles > 0) begin
         rsp_stall <= 1'b1;
         hold_off_cycles = hold_off_cycles - 1;
      end else if (!gaps_on) begin
         rsp_stall <= 1'b0;
      end else if (stall_run > 0) begin
         rsp_stall <= 1'b1;
         stall_run--;
      end else if (free_run > 0) begin
         rsp_stall <= 1'b0;
         free_run--;
      end else begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: free_run = $urandom_range(1, 8);
            5:             free_run = $urandom_range(20, 80);
            6, 7, 8:       stall_run = $urandom_range(1, 3);
            default:       stall_run = $urandom_range(8, 25);
         endcase
         rsp_stall <= 1'b0;
      end
   end

   function automatic int pick_send_gap();
      int r;
      if (!gaps_on) return 0;
      if (burst_left > 0) begin
         burst_left--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 5) begin
         burst_left = $urandom_range(20, 60);
         return 0;
      end
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 2);
      if (r < 96) return $urandom_range(3, 6);
      return $urandom_range(10, 30);
   endfunction

   task automatic send_tick(input logic pressed, input logic edge_flag);
      int gap;
      gap = pick_send_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_btn_down <= pressed;
      req_edge_seen <= edge_flag;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic wait_quiet();
      req_valid <= 1'b0;
      do @(posedge clock); while (expected_ticks.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_INDEX_BITS-1:0] idx,
                                 input logic [CFG_BITS-1:0] data);
      wait_quiet();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic set_times(input int debounce, input int long_press);
      write_register(CSR_DEBOUNCE, CFG_BITS'(debounce));
      write_register(CSR_LONG_PRESS, CFG_BITS'(long_press));
   endtask

   // mostly well-formed presses with random content, some noise
   task automatic run_press_traffic(input int target);
      int sent;
      int lead;
      int hold_len;
      int rel_len;
      int deb;
      int lp;
      sent = 0;
      deb = int'(debounce_q);
      lp = int'(long_press_q);
      while (sent < target) begin
         if ($urandom_range(0, 99) < 80) begin
            lead = $urandom_range(0, 3);
            repeat (lead) send_tick($urandom_range(0, 99) < 20, 1'b0);
            send_tick($urandom_range(0, 99) < 90, 1'b1);
            case ($urandom_range(0, 3))
               0:       hold_len = $urandom_range(0, deb);
               1:       hold_len = deb + $urandom_range(1, 10);
               2:       hold_len = deb + lp + $urandom_range(0, 5);
               default: hold_len = deb + $urandom_range(0, 3) + (lp < 60 ? lp : 60);
            endcase
            if (hold_len > 120) hold_len = 120;
            for (int k = 0; k < hold_len; k++)
               send_tick($urandom_range(0, 99) >= 6, $urandom_range(0, 99) < 8);
            rel_len = (deb < 60 ? deb : 60) + $urandom_range(0, 4);
            for (int k = 0; k < rel_len; k++)
               send_tick(k == rel_len - 1 && $urandom_range(0, 99) < 15,
                         $urandom_range(0, 99) < 4);
            sent += lead + 1 + hold_len + rel_len;
         end else begin
            lead = $urandom_range(1, 6);
            repeat (lead) send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            sent += lead;
         end
      end
   endtask

   task automatic test_press_and_bounce();
      set_times(2, 6);
      send_tick(1'b1, 1'b0);
      send_tick(1'b0, 1'b1);
      send_tick(1'b0, 1'b0);
      send_tick(1'b0, 1'b0);
      send_tick(1'b1, 1'b1);
      send_tick(1'b1, 1'b0);
      send_tick(1'b1, 1'b0);
      send_tick(1'b1, 1'b1);   // edge outside idle
      send_tick(1'b0, 1'b0);
      send_tick(1'b0, 1'b0);
      send_tick(1'b1, 1'b0);   // bounce back to held
      repeat (4) send_tick(1'b1, 1'b0);
      repeat (3) send_tick(1'b0, 1'b0);
      send_tick(1'b1, 1'b1);
      repeat (2) send_tick(1'b1, 1'b0);
      repeat (3) send_tick(1'b0, 1'b0);
   endtask

   task automatic test_zero_thresholds();
      set_times(0, 0);
      send_tick(1'b1, 1'b1);
      repeat (2) send_tick(1'b1, 1'b0);
      repeat (2) send_tick(1'b0, 1'b0);
      set_times(0, 4);
      send_tick(1'b1, 1'b1);
      send_tick(1'b1, 1'b0);
      repeat (2) send_tick(1'b0, 1'b0);
   endtask

   task automatic test_register_extremes();
      set_times(65535, 65535);
      send_tick(1'b1, 1'b1);
      repeat (5) send_tick(1'b1, 1'b0);
      send_tick(1'b0, 1'b0);
      write_register(CSR_SPARE_LO, '1);
      write_register(CSR_SPARE_HI, '0);
      write_register(CSR_SPARE_HI, CFG_BITS'($urandom_range(0, 65535)));
      write_register(CSR_DEBOUNCE, CFG_BITS'(1));
      repeat (2) send_tick(1'b1, 1'b0);
      repeat (3) send_tick(1'b0, 1'b0);
   endtask

   task automatic test_input_backpressure();
      set_times(3, 10);
      hold_off_cycles = 300;
      run_press_traffic(80);
   endtask

   task automatic test_random_traffic();
      int deb_set[8];
      int lp_set[8];
      deb_set = '{40, 0, 1, 2, 5, 3, 0, 0};
      lp_set = '{5000, 0, 1, 8, 20, 65535, 0, 0};
      deb_set[6] = $urandom_range(0, 12);
      lp_set[6] = $urandom_range(0, 40);
      deb_set[7] = $urandom_range(0, 12);
      lp_set[7] = $urandom_range(0, 40);
      for (int p = 0; p < 8; p++) begin
         set_times(deb_set[p], lp_set[p]);
         run_press_traffic(160);
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_press_and_bounce();
      test_zero_thresholds();
      test_register_extremes();
      test_input_backpressure();
      test_random_traffic();
      wait_quiet();
      $display("Checked %0d ticks: %0d short and %0d long press pulses, %0d register writes,",
               ticks_checked, short_pulses, long_pulses, csr_writes);
      $display("input held off for %0d cycles, %0d mismatches.", input_stall_cycles, error_count);
      if (error_count == 0 && expected_ticks.size() == 0) begin
         $display("tb_button_press_qualifier_core: clean");
      end else begin
         $display("tb_button_press_qualifier_core: errors");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("Timed out with %0d results outstanding", expected_ticks.size());
      $display("tb_button_press_qualifier_core: errors");
      $finish;
   end

endmodule
